@@ hw/rtl/idr_pkg.sv @@
// Package for the indexed ring-buffer deque: request and response structs,
// operation and status codes, and the all-ones word reported for empty reads.
// No dependencies.
package idr_pkg;

   localparam logic signed [31:0] NEG_ONE = 32'shFFFF_FFFF;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_READ       = 3'd4,
      FUNC_WRITE      = 3'd5,
      FUNC_STATUS     = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_FULL    = 2'd2
   } stat_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [9:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [10:0]        entry_count;
      logic signed [31:0] total;
      logic [1:0]         status;
   } rsp_type;

endpackage

@@ hw/rtl/idr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old word.
// No dependencies.
module idr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/indexed_deque_ring.sv @@
// Top level of the indexed ring-buffer deque of signed 32-bit words.
// Depends on idr_pkg and idr_ram.

// The block accepts one request per clock unless a stalled response holds it
// off and returns one response for each. A request is registered into the first
// stage, whose contents load the response register when the response side does
// not stall; the word store has a registered read port. The head pointer and
// count are updated at acceptance. The front word, back word and running sum
// are updated as the response is formed, so back-to-back requests see each
// other's effects without bubbles. The word store is not cleared after reset:
// only entries below the count are reported, and each was written by a push.
module indexed_deque_ring #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  idr_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output idr_pkg::rsp_type rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [1:0]         status;
      cnt_type            cnt;
      logic               was_empty;
      logic               at_front;
      logic               at_back;
   } stage_type;

   function automatic addr_type wrap_add(addr_type base, addr_type off);
      logic [AW:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic addr_type cnt_to_addr(cnt_type c);
      logic [AW+CW-1:0] w;
      w = (AW+CW)'(c);
      return w[AW-1:0];
   endfunction

   function automatic addr_type idx_to_addr(logic [9:0] i);
      logic [AW+9:0] w;
      w = (AW+10)'(i);
      return w[AW-1:0];
   endfunction

   logic               accept;
   logic               advance;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   stage_type          s1_ff, s1_in;
   addr_type           head_ff, head_in;
   cnt_type            count_ff, count_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [31:0] front_ff, front_in;
   logic signed [31:0] back_ff, back_in;
   idr_pkg::rsp_type   rsp_ff, rsp_in;

   logic               wr_en;
   addr_type           wr_addr;
   logic               rd_en;
   addr_type           rd_addr;
   logic [31:0]        rd_raw;
   logic signed [31:0] rd_word;

   logic [CW+9:0]      idx_w, cnt_w;
   logic               in_range;
   logic               is_full;
   logic               is_empty;
   cnt_type            back_off;
   logic [CW+10:0]     cnt_ext;

   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   idr_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_idr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_word = rd_raw;

   always_comb begin
      idx_w    = (CW+10)'(req.index);
      cnt_w    = (CW+10)'(count_ff);
      in_range = idx_w < cnt_w;
      is_full  = count_ff == cnt_type'(DEPTH);
      is_empty = count_ff == '0;
      back_off = (count_ff > cnt_type'(1)) ? count_ff - cnt_type'(2) : '0;

      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      rd_en    = accept;
      rd_addr  = head_ff;

      s1_in.func      = req.func;
      s1_in.value     = req.value;
      s1_in.status    = idr_pkg::STAT_DONE;
      s1_in.was_empty = is_empty;
      s1_in.at_front  = req.index == '0;
      s1_in.at_back   = idx_w == cnt_w - (CW+10)'(1);

      unique case (req.func)
         idr_pkg::FUNC_PUSH_FRONT: begin
            if (is_full) begin
               s1_in.status = idr_pkg::STAT_FULL;
            end else begin
               head_in  = (head_ff == '0) ? addr_type'(DEPTH - 1) : head_ff - addr_type'(1);
               wr_en    = accept;
               wr_addr  = head_in;
               count_in = count_ff + cnt_type'(1);
            end
         end
         idr_pkg::FUNC_PUSH_BACK: begin
            if (is_full) begin
               s1_in.status = idr_pkg::STAT_FULL;
            end else begin
               wr_en    = accept;
               wr_addr  = wrap_add(head_ff, cnt_to_addr(count_ff));
               count_in = count_ff + cnt_type'(1);
            end
         end
         idr_pkg::FUNC_POP_FRONT: begin
            if (is_empty) begin
               s1_in.status = idr_pkg::STAT_IGNORED;
            end else begin
               rd_addr  = wrap_add(head_ff, addr_type'(1));
               head_in  = rd_addr;
               count_in = count_ff - cnt_type'(1);
            end
         end
         idr_pkg::FUNC_POP_BACK: begin
            if (is_empty) begin
               s1_in.status = idr_pkg::STAT_IGNORED;
            end else begin
               rd_addr  = wrap_add(head_ff, cnt_to_addr(back_off));
               count_in = count_ff - cnt_type'(1);
            end
         end
         idr_pkg::FUNC_READ: begin
            if (!in_range) begin
               s1_in.status = idr_pkg::STAT_IGNORED;
            end else begin
               rd_addr = wrap_add(head_ff, idx_to_addr(req.index));
            end
         end
         idr_pkg::FUNC_WRITE: begin
            if (!in_range) begin
               s1_in.status = idr_pkg::STAT_IGNORED;
            end else begin
               rd_addr = wrap_add(head_ff, idx_to_addr(req.index));
               wr_en   = accept;
               wr_addr = rd_addr;
            end
         end
         default: begin
         end
      endcase

      s1_in.cnt = count_in;
   end

   always_comb begin
      sum_in   = sum_ff;
      front_in = front_ff;
      back_in  = back_ff;
      rsp_in.read_value = idr_pkg::NEG_ONE;

      if (s1_ff.status == idr_pkg::STAT_DONE) begin
         unique case (s1_ff.func)
            idr_pkg::FUNC_PUSH_FRONT: begin
               sum_in   = sum_ff + s1_ff.value;
               front_in = s1_ff.value;
               if (s1_ff.was_empty) begin
                  back_in = s1_ff.value;
               end
            end
            idr_pkg::FUNC_PUSH_BACK: begin
               sum_in  = sum_ff + s1_ff.value;
               back_in = s1_ff.value;
               if (s1_ff.was_empty) begin
                  front_in = s1_ff.value;
               end
            end
            idr_pkg::FUNC_POP_FRONT: begin
               sum_in   = sum_ff - front_ff;
               front_in = rd_word;
            end
            idr_pkg::FUNC_POP_BACK: begin
               sum_in  = sum_ff - back_ff;
               back_in = rd_word;
            end
            idr_pkg::FUNC_READ: begin
               rsp_in.read_value = rd_word;
            end
            idr_pkg::FUNC_WRITE: begin
               sum_in = sum_ff - rd_word + s1_ff.value;
               if (s1_ff.at_front) begin
                  front_in = s1_ff.value;
               end
               if (s1_ff.at_back) begin
                  back_in = s1_ff.value;
               end
            end
            default: begin
            end
         endcase
      end

      cnt_ext            = (CW+11)'(s1_ff.cnt);
      rsp_in.front_value = (s1_ff.cnt == '0) ? idr_pkg::NEG_ONE : front_in;
      rsp_in.back_value  = (s1_ff.cnt == '0) ? idr_pkg::NEG_ONE : back_in;
      rsp_in.entry_count = cnt_ext[10:0];
      rsp_in.total       = sum_in;
      rsp_in.status      = s1_ff.status;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (advance) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ hw/rtl/idr_checker.sv @@
// Port-level checker for the indexed ring-buffer deque, bound to the top level.
// Depends on idr_pkg and indexed_deque_ring.
module idr_checker #(
   parameter int DEPTH = 1024
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input idr_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input idr_pkg::rsp_type rsp
);

   // A stalled response keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   // Requests are held off only while a finished response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting response");

   // An empty deque reports no front or back word.
   assert property (@(posedge clock) disable iff (reset)
      (DEPTH < 2048) && rsp_valid && rsp.entry_count == '0 |->
         rsp.front_value == idr_pkg::NEG_ONE && rsp.back_value == idr_pkg::NEG_ONE)
      else $error("empty deque shows a front or back word");

   // A single stored word is both the front and the back.
   assert property (@(posedge clock) disable iff (reset)
      (DEPTH < 2048) && rsp_valid && rsp.entry_count == 11'd1 |->
         rsp.front_value == rsp.back_value)
      else $error("front and back differ with one word stored");

   // A rejected or ignored request returns no read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != idr_pkg::STAT_DONE |-> rsp.read_value == idr_pkg::NEG_ONE)
      else $error("read data returned on a failed request");

endmodule

bind indexed_deque_ring idr_checker #(.DEPTH(DEPTH)) u_idr_checker (.*);
